### design/csp_pkg.sv
package csp_pkg;
   localparam int COORD_BITS_DEF = 24;
   localparam int PARAM_BITS_DEF = 16;
   localparam int TENSION_BITS = 16;
   localparam int TENSION_FRAC = 15;
   localparam int WEIGHT_FRAC = 20;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [TENSION_BITS-1:0] TENSION_RESET = 16'd16384;
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_EVAL = 1'b1;
endpackage

### design/csp_front.sv
module csp_front
   import csp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int PARAM_BITS = PARAM_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   input  logic [PARAM_BITS-1:0]        req_param_t,
   output logic                         q_valid,
   input  logic                         q_take,
   output logic                         q_cmd,
   output logic [3*COORD_BITS-1:0]      q_point,
   output logic [PARAM_BITS-1:0]        q_param
);
   localparam int QDEPTH = QUEUE_DEPTH;
   localparam int W = 1 + 3*COORD_BITS + PARAM_BITS;
   localparam int AW = $clog2(QDEPTH);
   logic [W-1:0] mem_ff [QDEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic push;

   assign req_stall = (cnt_ff == (AW+1)'(QDEPTH));
   assign push = req_valid && !req_stall;
   assign q_valid = (cnt_ff != '0);
   assign {q_cmd, q_point, q_param} = mem_ff[rp_ff];

   always_comb begin
      wp_in = push ? ((wp_ff == AW'(QDEPTH-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in = q_take ? ((rp_ff == AW'(QDEPTH-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= {req_cmd, req_coord_x, req_coord_y, req_coord_z, req_param_t};
      end
   end
endmodule

### design/csp_back.sv
module csp_back
   import csp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int PARAM_BITS = PARAM_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [TENSION_BITS-1:0]      tension,
   input  logic                         q_valid,
   output logic                         q_take,
   input  logic                         q_cmd,
   input  logic [3*COORD_BITS-1:0]      q_point,
   input  logic [PARAM_BITS-1:0]        q_param,
   output logic                         busy,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_z,
   output logic                         rsp_clipped
);
   localparam int P = PARAM_BITS;
   localparam int WS = P + TENSION_FRAC;
   localparam int DN = WS - WEIGHT_FRAC;
   localparam int AB = WS + 4;
   localparam int WB = WEIGHT_FRAC + 4;
   localparam int SB = COORD_BITS + WB + 3;
   localparam logic signed [AB-1:0] ONE_C = AB'(1) <<< TENSION_FRAC;
   localparam logic signed [SB-1:0] ACC_HALF = SB'(1) <<< (WEIGHT_FRAC-1);

   typedef enum logic [2:0] {
      S_IDLE, S_T2, S_T3, S_W, S_MAC, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic signed [COORD_BITS-1:0] wx_ff [4], wy_ff [4], wz_ff [4];
   logic [P-1:0] t_ff, t_in, t2_ff, t2_in, t3_ff, t3_in;
   logic signed [WB-1:0] w_ff [4];
   logic signed [WB-1:0] w_in [4];
   logic [3:0] k_ff, k_in;
   logic signed [SB-1:0] acc_ff [3];
   logic signed [SB-1:0] acc_in [3];
   logic rv_ff, rv_in, cl_ff, cl_in;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic [2*P-1:0] sq;
   logic signed [AB-1:0] c, a0, a1, a2, a3, tt, tt2, tt3;
   logic signed [COORD_BITS-1:0] pa;
   logic signed [WB-1:0] wsel;
   logic signed [COORD_BITS+WB-1:0] prod;
   logic signed [COORD_BITS-1:0] sat [3];
   logic satc [3];
   logic signed [SB-1:0] hi, lo, r;

   function automatic logic signed [WB-1:0] rnd(input logic signed [AB-1:0] v);
      logic signed [AB-1:0] x;
      x = v + (AB'(1) <<< (DN-1));
      return WB'(x >>> DN);
   endfunction

   assign q_take = q_valid && (state_ff == S_IDLE);
   assign busy = (state_ff != S_IDLE) || rv_ff || q_valid;
   assign rsp_valid = rv_ff;
   assign rsp_pos_x = px_ff;
   assign rsp_pos_y = py_ff;
   assign rsp_pos_z = pz_ff;
   assign rsp_clipped = cl_ff;

   always_comb begin
      sq = (state_ff == S_T2) ? t_ff * t_ff : t2_ff * t_ff;
      c = AB'({1'b0, tension});
      tt = AB'({1'b0, t_ff});
      tt2 = AB'({1'b0, t2_ff});
      tt3 = AB'({1'b0, t3_ff});
      a0 = c * (-tt + 2*tt2 - tt3);
      a1 = (AB'(1) <<< WS) + tt2 * (c - 3*ONE_C) + tt3 * (2*ONE_C - c);
      a2 = tt * c + tt2 * (3*ONE_C - 2*c) + tt3 * (c - 2*ONE_C);
      a3 = c * (tt3 - tt2);
      case (k_ff[1:0])
         2'd0: wsel = w_ff[0];
         2'd1: wsel = w_ff[1];
         2'd2: wsel = w_ff[2];
         default: wsel = w_ff[3];
      endcase
      case (k_ff[3:2])
         2'd0: pa = wx_ff[k_ff[1:0]];
         2'd1: pa = wy_ff[k_ff[1:0]];
         default: pa = wz_ff[k_ff[1:0]];
      endcase
      prod = pa * wsel;
      hi = SB'((64'sd1 <<< (COORD_BITS-1)) - 1);
      lo = -SB'(64'sd1 <<< (COORD_BITS-1));
      for (int i = 0; i < 3; i++) begin
         r = (acc_ff[i] + ACC_HALF) >>> WEIGHT_FRAC;
         satc[i] = (r > hi) || (r < lo);
         sat[i] = (r > hi) ? COORD_BITS'(hi) : (r < lo) ? COORD_BITS'(lo)
                  : COORD_BITS'(r);
      end
   end

   always_comb begin
      state_in = state_ff;
      t_in = t_ff; t2_in = t2_ff; t3_in = t3_ff;
      w_in = w_ff; k_in = k_ff; acc_in = acc_ff;
      rv_in = rv_ff && rsp_stall;
      cl_in = cl_ff; px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_take && q_cmd == CMD_EVAL) begin
               t_in = q_param;
               state_in = S_T2;
            end
         end
         S_T2: begin
            t2_in = P'((sq + (2*P)'(1 << (P-1))) >> P);
            state_in = S_T3;
         end
         S_T3: begin
            t3_in = P'((sq + (2*P)'(1 << (P-1))) >> P);
            state_in = S_W;
         end
         S_W: begin
            w_in[0] = rnd(a0); w_in[1] = rnd(a1);
            w_in[2] = rnd(a2); w_in[3] = rnd(a3);
            k_in = '0;
            for (int i = 0; i < 3; i++) acc_in[i] = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            acc_in[k_ff[3:2]] = acc_ff[k_ff[3:2]] + SB'(prod);
            k_in = k_ff + 1'b1;
            if (k_ff == 4'd11) state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               px_in = sat[0]; py_in = sat[1]; pz_in = sat[2];
               cl_in = satc[0] || satc[1] || satc[2];
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            wx_ff[i] <= '0; wy_ff[i] <= '0; wz_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
         if (q_take && q_cmd == CMD_PUSH) begin
            for (int i = 0; i < 3; i++) begin
               wx_ff[i] <= wx_ff[i+1]; wy_ff[i] <= wy_ff[i+1]; wz_ff[i] <= wz_ff[i+1];
            end
            wx_ff[3] <= q_point[3*COORD_BITS-1:2*COORD_BITS];
            wy_ff[3] <= q_point[2*COORD_BITS-1:COORD_BITS];
            wz_ff[3] <= q_point[COORD_BITS-1:0];
         end
      end
      t_ff <= t_in; t2_ff <= t2_in; t3_ff <= t3_in;
      w_ff <= w_in; k_ff <= k_in; acc_ff <= acc_in;
      cl_ff <= cl_in; px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
   end
endmodule

### design/cardinal_spline_point_evaluator_unit.sv
// Cardinal spline point evaluator over a window of the last four pushed points.
// The request channel (req_valid/req_stall) carries one item: cmd selects a
// push of coord_x/y/z into the window or an evaluation at param_t. Requests
// pass through a two-entry queue, so the front side keeps accepting while
// the evaluation unit is busy or its result is held.
// A push waits in the queue until the evaluation unit is idle; the unit shifts
// it into the window without leaving its idle state and gives no result. An
// evaluation occupies the unit for two squaring steps, one weight step, twelve
// multiply-accumulate steps on the shared coordinate-by-weight multiplier and
// one rounding and saturation step; the unit takes no new item from the queue
// until its evaluation has ended.
// The result channel (rsp_valid/rsp_stall) holds the point and the clipped
// flag in an output register until taken. While it is held, pushes go on, a
// further evaluation waits in its last step, and once the queue is full
// req_stall rises.
// The tension register is written through csr_valid/csr_ready; csr_ready is
// high only while no item is in flight.
// Reset, synchronous and active high, clears the window to zero, sets the
// tension to one half and empties the queue and the output register.
module cardinal_spline_point_evaluator_unit
   import csp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int PARAM_BITS = PARAM_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [TENSION_BITS-1:0]      csr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   input  logic signed [COORD_BITS-1:0] req_coord_z,
   input  logic [PARAM_BITS-1:0]        req_param_t,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pos_x,
   output logic signed [COORD_BITS-1:0] rsp_pos_y,
   output logic signed [COORD_BITS-1:0] rsp_pos_z,
   output logic                         rsp_clipped
);
   logic [TENSION_BITS-1:0] tension_ff;
   logic q_valid, q_take, q_cmd, busy;
   logic [3*COORD_BITS-1:0] q_point;
   logic [PARAM_BITS-1:0] q_param;

   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= TENSION_RESET;
      end else if (csr_valid && csr_ready) begin
         tension_ff <= csr_data;
      end
   end

   csp_front #(.COORD_BITS(COORD_BITS), .PARAM_BITS(PARAM_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_coord_x,
      .req_coord_y, .req_coord_z, .req_param_t, .q_valid, .q_take, .q_cmd,
      .q_point, .q_param
   );

   csp_back #(.COORD_BITS(COORD_BITS), .PARAM_BITS(PARAM_BITS)) u_back (
      .clock, .reset, .tension(tension_ff), .q_valid, .q_take, .q_cmd,
      .q_point, .q_param, .busy, .rsp_valid, .rsp_stall, .rsp_pos_x,
      .rsp_pos_y, .rsp_pos_z, .rsp_clipped
   );
endmodule
